@@ hdl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Check that a condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant failed");

`endif

@@ hdl/mbe_pkg.sv @@
// Types, constants and the action table of the middle button emulator.
package mbe_pkg;

    // Emulation states
    typedef enum logic [3:0] {
        ST_GROUND          = 4'd0,
        ST_DELAYED_LEFT    = 4'd1,
        ST_DELAYED_RIGHT   = 4'd2,
        ST_PRESSED_MIDDLE  = 4'd3,
        ST_PRESSED_LEFT    = 4'd4,
        ST_PRESSED_RIGHT   = 4'd5,
        ST_RELEASED_LEFT   = 4'd6,
        ST_RELEASED_RIGHT  = 4'd7,
        ST_REPRESSED_LEFT  = 4'd8,
        ST_REPRESSED_RIGHT = 4'd9,
        ST_BOTH            = 4'd10
    } emu_state_t;

    // Opcodes of the input word
    localparam logic OP_BUTTON = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Physical button numbers
    localparam logic [4:0] BTN_LEFT   = 5'd1;
    localparam logic [4:0] BTN_MIDDLE = 5'd2;
    localparam logic [4:0] BTN_RIGHT  = 5'd3;

    // Mode register codes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_AUTO = 2'd2;

    // Held-set bits
    localparam int HELD_LEFT  = 0;
    localparam int HELD_RIGHT = 1;

    // Table columns: held set, then timeout
    localparam logic [2:0] COL_NONE    = 3'd0;
    localparam logic [2:0] COL_LEFT    = 3'd1;
    localparam logic [2:0] COL_RIGHT   = 3'd2;
    localparam logic [2:0] COL_BOTH    = 3'd3;
    localparam logic [2:0] COL_TIMEOUT = 3'd4;

    // Register indexes and reset values
    localparam logic REG_MODE    = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;
    localparam logic [1:0]  MODE_RESET    = MODE_AUTO;
    localparam logic [15:0] TIMEOUT_RESET = 16'd50;

    // Input word
    typedef struct packed {
        logic       opcode;
        logic [4:0] button_number;
        logic       is_press;
    } mbe_in_t;

    // Result word
    typedef struct packed {
        logic       first_valid;
        logic [1:0] first_button;
        logic       first_press;
        logic       second_valid;
        logic [1:0] second_button;
        logic       second_press;
        logic       swallowed;
    } mbe_out_t;

    // One synthetic button event
    typedef struct packed {
        logic       vld;
        logic [1:0] btn;
        logic       press;
    } emu_act_t;

    // One table entry
    typedef struct packed {
        emu_act_t   a0;
        emu_act_t   a1;
        emu_state_t next;
    } emu_entry_t;

    // Emulator state carried between words
    typedef struct packed {
        emu_state_t  st;
        logic [1:0]  held;
        logic        armed;
        logic [15:0] remaining;
        logic        auto_off;
    } emu_ctx_t;

    // Configuration seen by the step logic
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] timeout_ms;
    } emu_cfg_t;

    // Decode a signed action code: +b press, -b release, 0 none
    function automatic emu_act_t act_f(input logic signed [2:0] a);
        emu_act_t         r;
        logic signed [2:0] mag;
        mag = -a;
        r = '0;
        if (a != 3'sd0)
        begin
            r.vld   = 1'b1;
            r.press = ~a[2];
            r.btn   = a[2] ? mag[1:0] : a[1:0];
        end
        return r;
    endfunction

    function automatic emu_entry_t mk(input logic signed [2:0] a0,
                                      input logic signed [2:0] a1,
                                      input emu_state_t nx);
        emu_entry_t r;
        r.a0   = act_f(a0);
        r.a1   = act_f(a1);
        r.next = nx;
        return r;
    endfunction

    // Action table: row by state, column by held set or timeout
    function automatic emu_entry_t emu_row(input emu_state_t s, input logic [2:0] col);
        emu_entry_t e;
        e = mk(3'sd0, 3'sd0, ST_GROUND);
        case (s)
            ST_DELAYED_LEFT:
                case (col)
                    COL_NONE:    e = mk(3'sd1, -3'sd1, ST_GROUND);
                    COL_LEFT:    e = mk(3'sd0, 3'sd0, ST_DELAYED_LEFT);
                    COL_RIGHT:   e = mk(3'sd1, -3'sd1, ST_DELAYED_RIGHT);
                    COL_BOTH:    e = mk(3'sd2, 3'sd0, ST_PRESSED_MIDDLE);
                    COL_TIMEOUT: e = mk(3'sd1, 3'sd0, ST_PRESSED_LEFT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_DELAYED_RIGHT:
                case (col)
                    COL_NONE:    e = mk(3'sd3, -3'sd3, ST_GROUND);
                    COL_LEFT:    e = mk(3'sd3, -3'sd3, ST_DELAYED_LEFT);
                    COL_RIGHT:   e = mk(3'sd0, 3'sd0, ST_DELAYED_RIGHT);
                    COL_BOTH:    e = mk(3'sd2, 3'sd0, ST_PRESSED_MIDDLE);
                    COL_TIMEOUT: e = mk(3'sd3, 3'sd0, ST_PRESSED_RIGHT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_PRESSED_MIDDLE:
                case (col)
                    COL_NONE:    e = mk(-3'sd2, 3'sd0, ST_GROUND);
                    COL_LEFT:    e = mk(3'sd0, 3'sd0, ST_RELEASED_RIGHT);
                    COL_RIGHT:   e = mk(3'sd0, 3'sd0, ST_RELEASED_LEFT);
                    COL_BOTH:    e = mk(3'sd0, 3'sd0, ST_PRESSED_MIDDLE);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_PRESSED_MIDDLE);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_PRESSED_LEFT:
                case (col)
                    COL_NONE:    e = mk(-3'sd1, 3'sd0, ST_GROUND);
                    COL_LEFT:    e = mk(3'sd0, 3'sd0, ST_PRESSED_LEFT);
                    COL_RIGHT:   e = mk(-3'sd1, 3'sd0, ST_DELAYED_RIGHT);
                    COL_BOTH:    e = mk(3'sd3, 3'sd0, ST_BOTH);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_PRESSED_LEFT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_PRESSED_RIGHT:
                case (col)
                    COL_NONE:    e = mk(-3'sd3, 3'sd0, ST_GROUND);
                    COL_LEFT:    e = mk(-3'sd3, 3'sd0, ST_DELAYED_LEFT);
                    COL_RIGHT:   e = mk(3'sd0, 3'sd0, ST_PRESSED_RIGHT);
                    COL_BOTH:    e = mk(3'sd1, 3'sd0, ST_BOTH);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_PRESSED_RIGHT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_RELEASED_LEFT:
                case (col)
                    COL_NONE:    e = mk(-3'sd2, 3'sd0, ST_GROUND);
                    COL_LEFT:    e = mk(-3'sd2, 3'sd0, ST_DELAYED_LEFT);
                    COL_RIGHT:   e = mk(3'sd0, 3'sd0, ST_RELEASED_LEFT);
                    COL_BOTH:    e = mk(3'sd1, 3'sd0, ST_REPRESSED_LEFT);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_RELEASED_LEFT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_RELEASED_RIGHT:
                case (col)
                    COL_NONE:    e = mk(-3'sd2, 3'sd0, ST_GROUND);
                    COL_LEFT:    e = mk(3'sd0, 3'sd0, ST_RELEASED_RIGHT);
                    COL_RIGHT:   e = mk(-3'sd2, 3'sd0, ST_DELAYED_RIGHT);
                    COL_BOTH:    e = mk(3'sd3, 3'sd0, ST_REPRESSED_RIGHT);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_RELEASED_RIGHT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_REPRESSED_LEFT:
                case (col)
                    COL_NONE:    e = mk(-3'sd2, -3'sd1, ST_GROUND);
                    COL_LEFT:    e = mk(-3'sd2, 3'sd0, ST_PRESSED_LEFT);
                    COL_RIGHT:   e = mk(-3'sd1, 3'sd0, ST_RELEASED_LEFT);
                    COL_BOTH:    e = mk(3'sd0, 3'sd0, ST_REPRESSED_LEFT);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_REPRESSED_LEFT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_REPRESSED_RIGHT:
                case (col)
                    COL_NONE:    e = mk(-3'sd2, -3'sd3, ST_GROUND);
                    COL_LEFT:    e = mk(-3'sd3, 3'sd0, ST_RELEASED_RIGHT);
                    COL_RIGHT:   e = mk(-3'sd2, 3'sd0, ST_PRESSED_RIGHT);
                    COL_BOTH:    e = mk(3'sd0, 3'sd0, ST_REPRESSED_RIGHT);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_REPRESSED_RIGHT);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            ST_BOTH:
                case (col)
                    COL_NONE:    e = mk(-3'sd1, -3'sd3, ST_GROUND);
                    COL_LEFT:    e = mk(-3'sd3, 3'sd0, ST_PRESSED_LEFT);
                    COL_RIGHT:   e = mk(-3'sd1, 3'sd0, ST_PRESSED_RIGHT);
                    COL_BOTH:    e = mk(3'sd0, 3'sd0, ST_BOTH);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_BOTH);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
            default:
                // ground, and any code outside the state list
                case (col)
                    COL_NONE:    e = mk(3'sd0, 3'sd0, ST_GROUND);
                    COL_LEFT:    e = mk(3'sd0, 3'sd0, ST_DELAYED_LEFT);
                    COL_RIGHT:   e = mk(3'sd0, 3'sd0, ST_DELAYED_RIGHT);
                    COL_BOTH:    e = mk(3'sd2, 3'sd0, ST_PRESSED_MIDDLE);
                    COL_TIMEOUT: e = mk(3'sd0, 3'sd0, ST_GROUND);
                    default:     e = mk(3'sd0, 3'sd0, ST_GROUND);
                endcase
        endcase
        return e;
    endfunction

endpackage

@@ hdl/middle_button_emulation_fsm.sv @@
// Top level of the middle button emulator: word stages, state and register port.
// A result word is built from the input register and held in the result register.
// One word per cycle while the receiver takes results; the input register refills
// while the result register is taken, so both stages move together.
// Reset (rst_n low, asynchronous): state ground, nothing held, countdown
// disarmed, mode auto, timeout 50 ms, both stages empty.
module middle_button_emulation_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mbe_pkg::mbe_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mbe_pkg::mbe_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic              in_valid_reg;
    mbe_pkg::mbe_in_t  in_data_reg;
    logic              out_valid_reg;
    mbe_pkg::mbe_out_t out_data_reg;
    mbe_pkg::emu_ctx_t ctx_reg;
    mbe_pkg::emu_ctx_t ctx_next;
    mbe_pkg::mbe_out_t result_next;
    logic [1:0]        mode_reg;
    logic [15:0]       timeout_reg;
    mbe_pkg::emu_cfg_t cfg;
    logic              advance;
    logic              cfg_write;
    logic              reg_index;

    // Move a word from the input register to the result register
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Register port decode
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;
    assign cfg.mode       = mode_reg;
    assign cfg.timeout_ms = timeout_reg;

    always_comb
    begin
        case (reg_index)
            mbe_pkg::REG_MODE:    prdata = {30'd0, mode_reg};
            mbe_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            default:              prdata = 32'd0;
        endcase
    end

    mbe_step u_step (
        .word     (in_data_reg),
        .ctx      (ctx_reg),
        .cfg      (cfg),
        .ctx_next (ctx_next),
        .result   (result_next)
    );

    // Hold the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    // Emulator state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.st        <= mbe_pkg::ST_GROUND;
            ctx_reg.held      <= 2'b00;
            ctx_reg.armed     <= 1'b0;
            ctx_reg.remaining <= 16'd0;
            ctx_reg.auto_off  <= 1'b0;
            mode_reg          <= mbe_pkg::MODE_RESET;
            timeout_reg       <= mbe_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (advance)
            begin
                ctx_reg <= ctx_next;
            end
            if (cfg_write)
            begin
                case (reg_index)
                    mbe_pkg::REG_MODE:
                    begin
                        mode_reg         <= pwdata[1:0];
                        ctx_reg.auto_off <= 1'b0;
                    end
                    mbe_pkg::REG_TIMEOUT:
                    begin
                        timeout_reg <= pwdata[15:0];
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

endmodule

@@ hdl/mbe_step.sv @@
// Combinational step: one input word against the current emulator state.
module mbe_step (
    input  mbe_pkg::mbe_in_t  word,
    input  mbe_pkg::emu_ctx_t ctx,
    input  mbe_pkg::emu_cfg_t cfg,
    output mbe_pkg::emu_ctx_t ctx_next,
    output mbe_pkg::mbe_out_t result
);

    mbe_pkg::emu_entry_t ev_entry;
    mbe_pkg::emu_entry_t to_entry;
    mbe_pkg::emu_entry_t arm_entry;
    logic [1:0]          held_new;
    logic [15:0]         remaining_dec;
    logic                emu_on;
    logic                is_lr;

    // Decode the word and look up the table entries it may need
    always_comb
    begin
        held_new = ctx.held;
        if (word.button_number == mbe_pkg::BTN_LEFT)
        begin
            held_new[mbe_pkg::HELD_LEFT] = word.is_press;
        end
        else
        begin
            held_new[mbe_pkg::HELD_RIGHT] = word.is_press;
        end
        remaining_dec = (ctx.remaining != 16'd0) ? 16'(ctx.remaining - 16'd1) : 16'd0;
        emu_on        = (cfg.mode != mbe_pkg::MODE_OFF) && !ctx.auto_off;
        is_lr         = (word.button_number == mbe_pkg::BTN_LEFT) ||
                        (word.button_number == mbe_pkg::BTN_RIGHT);
        ev_entry      = mbe_pkg::emu_row(ctx.st, {1'b0, held_new});
        to_entry      = mbe_pkg::emu_row(ctx.st, mbe_pkg::COL_TIMEOUT);
        arm_entry     = mbe_pkg::emu_row(ev_entry.next, mbe_pkg::COL_TIMEOUT);
    end

    // Advance state and build the result word
    always_comb
    begin
        ctx_next = ctx;
        result   = '0;
        if (word.opcode == mbe_pkg::OP_TICK)
        begin
            // count down, fire the timeout action at zero
            if (ctx.armed)
            begin
                ctx_next.remaining = remaining_dec;
                if (remaining_dec == 16'd0)
                begin
                    ctx_next.armed = 1'b0;
                    if (to_entry.a0.vld)
                    begin
                        result.first_valid  = 1'b1;
                        result.first_button = to_entry.a0.btn;
                        result.first_press  = to_entry.a0.press;
                        ctx_next.st         = to_entry.next;
                    end
                end
            end
        end
        else if (emu_on)
        begin
            if (word.button_number == mbe_pkg::BTN_MIDDLE && cfg.mode == mbe_pkg::MODE_AUTO)
            begin
                // real middle seen: hand control back to the user
                ctx_next.auto_off = 1'b1;
            end
            else if (is_lr)
            begin
                ctx_next.held        = held_new;
                ctx_next.st          = ev_entry.next;
                result.first_valid   = ev_entry.a0.vld;
                result.first_button  = ev_entry.a0.btn;
                result.first_press   = ev_entry.a0.press;
                result.second_valid  = ev_entry.a1.vld;
                result.second_button = ev_entry.a1.btn;
                result.second_press  = ev_entry.a1.press;
                result.swallowed     = ev_entry.a0.vld | ev_entry.a1.vld;
                // arm the countdown when entering a delayed state
                if (arm_entry.a0.vld)
                begin
                    ctx_next.remaining = cfg.timeout_ms;
                    ctx_next.armed     = 1'b1;
                    result.swallowed   = 1'b1;
                end
                else
                begin
                    ctx_next.armed = 1'b0;
                end
            end
        end
    end

endmodule

@@ hdl/mbe_checker.sv @@
// Port-level checker for the middle button emulator, bound to the top level.
`include "assert_macros.svh"

module mbe_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input mbe_pkg::mbe_out_t out_data,
    input logic              pready
);

    // A stalled result word stays offered and unchanged
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

    // The register port never inserts wait states
    `ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready)

    // An absent first event reads as zero
    `ASSERT_IMPLY(a_first_zero, clk, rst_n, out_valid && !out_data.first_valid,
                  out_data.first_button == 2'd0 && !out_data.first_press)

    // A second event only follows a first one
    `ASSERT_IMPLY(a_second_needs_first, clk, rst_n, out_valid && out_data.second_valid,
                  out_data.first_valid && out_data.swallowed)

endmodule

bind middle_button_emulation_fsm mbe_checker u_mbe_checker (.*);

@@ tb/emulation_checker.sv @@
// Watches the emulator's word channels and register port, predicts each result word and compares.
module emulation_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  mbe_pkg::mbe_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  mbe_pkg::mbe_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                error_count,
    output int                pending_words
);

    localparam logic [1:0]        B_LEFT  = mbe_pkg::BTN_LEFT[1:0];
    localparam logic [1:0]        B_MID   = mbe_pkg::BTN_MIDDLE[1:0];
    localparam logic [1:0]        B_RIGHT = mbe_pkg::BTN_RIGHT[1:0];
    localparam mbe_pkg::emu_act_t NIL     = '0;

    // Register copies and emulator state as the block should hold them
    logic [1:0]          emu_mode;
    logic [15:0]         emu_timeout;
    mbe_pkg::emu_state_t cur_state;
    logic [1:0]          held;
    logic                armed;
    logic [15:0]         remaining;
    logic                auto_off;

    mbe_pkg::mbe_out_t   predicted_events[$];
    mbe_pkg::mbe_out_t   want;
    logic [31:0]         reg_expect;
    int                  results_seen;

    function automatic mbe_pkg::emu_act_t down(input logic [1:0] b);
        mbe_pkg::emu_act_t a;
        a.vld   = 1'b1;
        a.btn   = b;
        a.press = 1'b1;
        return a;
    endfunction

    function automatic mbe_pkg::emu_act_t up(input logic [1:0] b);
        mbe_pkg::emu_act_t a;
        a.vld   = 1'b1;
        a.btn   = b;
        a.press = 1'b0;
        return a;
    endfunction

    function automatic mbe_pkg::emu_entry_t go(input mbe_pkg::emu_act_t a0,
                                               input mbe_pkg::emu_act_t a1,
                                               input mbe_pkg::emu_state_t nx);
        mbe_pkg::emu_entry_t e;
        e.a0   = a0;
        e.a1   = a1;
        e.next = nx;
        return e;
    endfunction

    // Action for a state and a held set (or the timeout column); unlisted pairs stay put
    function automatic mbe_pkg::emu_entry_t transition(input mbe_pkg::emu_state_t s,
                                                       input logic [2:0] col);
        mbe_pkg::emu_entry_t e;
        case ({s, col})
            {mbe_pkg::ST_GROUND, mbe_pkg::COL_LEFT}:
                e = go(NIL, NIL, mbe_pkg::ST_DELAYED_LEFT);
            {mbe_pkg::ST_GROUND, mbe_pkg::COL_RIGHT}:
                e = go(NIL, NIL, mbe_pkg::ST_DELAYED_RIGHT);
            {mbe_pkg::ST_GROUND, mbe_pkg::COL_BOTH}:
                e = go(down(B_MID), NIL, mbe_pkg::ST_PRESSED_MIDDLE);
            {mbe_pkg::ST_DELAYED_LEFT, mbe_pkg::COL_NONE}:
                e = go(down(B_LEFT), up(B_LEFT), mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_DELAYED_LEFT, mbe_pkg::COL_RIGHT}:
                e = go(down(B_LEFT), up(B_LEFT), mbe_pkg::ST_DELAYED_RIGHT);
            {mbe_pkg::ST_DELAYED_LEFT, mbe_pkg::COL_BOTH}:
                e = go(down(B_MID), NIL, mbe_pkg::ST_PRESSED_MIDDLE);
            {mbe_pkg::ST_DELAYED_LEFT, mbe_pkg::COL_TIMEOUT}:
                e = go(down(B_LEFT), NIL, mbe_pkg::ST_PRESSED_LEFT);
            {mbe_pkg::ST_DELAYED_RIGHT, mbe_pkg::COL_NONE}:
                e = go(down(B_RIGHT), up(B_RIGHT), mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_DELAYED_RIGHT, mbe_pkg::COL_LEFT}:
                e = go(down(B_RIGHT), up(B_RIGHT), mbe_pkg::ST_DELAYED_LEFT);
            {mbe_pkg::ST_DELAYED_RIGHT, mbe_pkg::COL_BOTH}:
                e = go(down(B_MID), NIL, mbe_pkg::ST_PRESSED_MIDDLE);
            {mbe_pkg::ST_DELAYED_RIGHT, mbe_pkg::COL_TIMEOUT}:
                e = go(down(B_RIGHT), NIL, mbe_pkg::ST_PRESSED_RIGHT);
            {mbe_pkg::ST_PRESSED_MIDDLE, mbe_pkg::COL_NONE}:
                e = go(up(B_MID), NIL, mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_PRESSED_MIDDLE, mbe_pkg::COL_LEFT}:
                e = go(NIL, NIL, mbe_pkg::ST_RELEASED_RIGHT);
            {mbe_pkg::ST_PRESSED_MIDDLE, mbe_pkg::COL_RIGHT}:
                e = go(NIL, NIL, mbe_pkg::ST_RELEASED_LEFT);
            {mbe_pkg::ST_PRESSED_LEFT, mbe_pkg::COL_NONE}:
                e = go(up(B_LEFT), NIL, mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_PRESSED_LEFT, mbe_pkg::COL_RIGHT}:
                e = go(up(B_LEFT), NIL, mbe_pkg::ST_DELAYED_RIGHT);
            {mbe_pkg::ST_PRESSED_LEFT, mbe_pkg::COL_BOTH}:
                e = go(down(B_RIGHT), NIL, mbe_pkg::ST_BOTH);
            {mbe_pkg::ST_PRESSED_RIGHT, mbe_pkg::COL_NONE}:
                e = go(up(B_RIGHT), NIL, mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_PRESSED_RIGHT, mbe_pkg::COL_LEFT}:
                e = go(up(B_RIGHT), NIL, mbe_pkg::ST_DELAYED_LEFT);
            {mbe_pkg::ST_PRESSED_RIGHT, mbe_pkg::COL_BOTH}:
                e = go(down(B_LEFT), NIL, mbe_pkg::ST_BOTH);
            {mbe_pkg::ST_RELEASED_LEFT, mbe_pkg::COL_NONE}:
                e = go(up(B_MID), NIL, mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_RELEASED_LEFT, mbe_pkg::COL_LEFT}:
                e = go(up(B_MID), NIL, mbe_pkg::ST_DELAYED_LEFT);
            {mbe_pkg::ST_RELEASED_LEFT, mbe_pkg::COL_BOTH}:
                e = go(down(B_LEFT), NIL, mbe_pkg::ST_REPRESSED_LEFT);
            {mbe_pkg::ST_RELEASED_RIGHT, mbe_pkg::COL_NONE}:
                e = go(up(B_MID), NIL, mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_RELEASED_RIGHT, mbe_pkg::COL_RIGHT}:
                e = go(up(B_MID), NIL, mbe_pkg::ST_DELAYED_RIGHT);
            {mbe_pkg::ST_RELEASED_RIGHT, mbe_pkg::COL_BOTH}:
                e = go(down(B_RIGHT), NIL, mbe_pkg::ST_REPRESSED_RIGHT);
            {mbe_pkg::ST_REPRESSED_LEFT, mbe_pkg::COL_NONE}:
                e = go(up(B_MID), up(B_LEFT), mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_REPRESSED_LEFT, mbe_pkg::COL_LEFT}:
                e = go(up(B_MID), NIL, mbe_pkg::ST_PRESSED_LEFT);
            {mbe_pkg::ST_REPRESSED_LEFT, mbe_pkg::COL_RIGHT}:
                e = go(up(B_LEFT), NIL, mbe_pkg::ST_RELEASED_LEFT);
            {mbe_pkg::ST_REPRESSED_RIGHT, mbe_pkg::COL_NONE}:
                e = go(up(B_MID), up(B_RIGHT), mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_REPRESSED_RIGHT, mbe_pkg::COL_LEFT}:
                e = go(up(B_RIGHT), NIL, mbe_pkg::ST_RELEASED_RIGHT);
            {mbe_pkg::ST_REPRESSED_RIGHT, mbe_pkg::COL_RIGHT}:
                e = go(up(B_MID), NIL, mbe_pkg::ST_PRESSED_RIGHT);
            {mbe_pkg::ST_BOTH, mbe_pkg::COL_NONE}:
                e = go(up(B_LEFT), up(B_RIGHT), mbe_pkg::ST_GROUND);
            {mbe_pkg::ST_BOTH, mbe_pkg::COL_LEFT}:
                e = go(up(B_RIGHT), NIL, mbe_pkg::ST_PRESSED_LEFT);
            {mbe_pkg::ST_BOTH, mbe_pkg::COL_RIGHT}:
                e = go(up(B_LEFT), NIL, mbe_pkg::ST_PRESSED_RIGHT);
            default:
                e = go(NIL, NIL, s);
        endcase
        return e;
    endfunction

    // Advance the emulator by one input word and return the result word it should give
    function automatic mbe_pkg::mbe_out_t emulate_word(input mbe_pkg::mbe_in_t w);
        mbe_pkg::mbe_out_t   r;
        mbe_pkg::emu_entry_t e;
        r = '0;
        if (w.opcode == mbe_pkg::OP_TICK)
        begin
            // count down while armed; fire the timeout action at zero
            if (armed)
            begin
                if (remaining != 16'd0)
                    remaining = remaining - 16'd1;
                if (remaining == 16'd0)
                begin
                    armed = 1'b0;
                    e = transition(cur_state, mbe_pkg::COL_TIMEOUT);
                    if (e.a0.vld)
                    begin
                        {r.first_valid, r.first_button, r.first_press} = e.a0;
                        cur_state = e.next;
                    end
                end
            end
        end
        else if (emu_mode != mbe_pkg::MODE_OFF && !auto_off)
        begin
            if (w.button_number == mbe_pkg::BTN_MIDDLE && emu_mode == mbe_pkg::MODE_AUTO)
                auto_off = 1'b1;
            else if (w.button_number == mbe_pkg::BTN_LEFT ||
                     w.button_number == mbe_pkg::BTN_RIGHT)
            begin
                held[(w.button_number == mbe_pkg::BTN_LEFT) ? mbe_pkg::HELD_LEFT
                                                           : mbe_pkg::HELD_RIGHT] = w.is_press;
                e = transition(cur_state, {1'b0, held});
                {r.first_valid, r.first_button, r.first_press}    = e.a0;
                {r.second_valid, r.second_button, r.second_press} = e.a1;
                r.swallowed = e.a0.vld | e.a1.vld;
                cur_state = e.next;
                // arm the countdown when the new state waits for the other button
                e = transition(cur_state, mbe_pkg::COL_TIMEOUT);
                if (e.a0.vld)
                begin
                    remaining   = emu_timeout;
                    armed       = 1'b1;
                    r.swallowed = 1'b1;
                end
                else
                    armed = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic string event_text(input mbe_pkg::mbe_out_t r);
        return $sformatf("first %b/%0d/%b second %b/%0d/%b swallowed %b",
                         r.first_valid, r.first_button, r.first_press,
                         r.second_valid, r.second_button, r.second_press, r.swallowed);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emu_mode     = mbe_pkg::MODE_RESET;
            emu_timeout  = mbe_pkg::TIMEOUT_RESET;
            cur_state    = mbe_pkg::ST_GROUND;
            held         = 2'b00;
            armed        = 1'b0;
            remaining    = 16'd0;
            auto_off     = 1'b0;
            results_seen = 0;
            error_count  = 0;
            predicted_events.delete();
            pending_words <= 0;
        end
        else
        begin
            // track register writes and check read data
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == mbe_pkg::REG_MODE)
                    begin
                        emu_mode = pwdata[1:0];
                        auto_off = 1'b0;
                    end
                    else
                        emu_timeout = pwdata[15:0];
                end
                else
                begin
                    reg_expect = (paddr[2] == mbe_pkg::REG_MODE) ? {30'd0, emu_mode}
                                                                 : {16'd0, emu_timeout};
                    if (prdata !== reg_expect)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("register read at %0d: expected %h, got %h",
                                     paddr, reg_expect, prdata);
                    end
                end
            end

            // compare each result word with the oldest prediction
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_events.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result word %0d with nothing expected: %s",
                                 results_seen, event_text(out_data));
                end
                else
                begin
                    want = predicted_events.pop_front();
                    if (out_data.first_valid   !== want.first_valid   ||
                        out_data.first_button  !== want.first_button  ||
                        out_data.first_press   !== want.first_press   ||
                        out_data.second_valid  !== want.second_valid  ||
                        out_data.second_button !== want.second_button ||
                        out_data.second_press  !== want.second_press  ||
                        out_data.swallowed     !== want.swallowed)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result word %0d: expected %s, got %s", results_seen,
                                     event_text(want), event_text(out_data));
                    end
                end
            end

            // predict the result of each accepted input word
            if (in_valid && in_ready)
                predicted_events.push_back(emulate_word(in_data));

            pending_words <= predicted_events.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the middle button emulator testbench: clock, reset, stimulus and verdict.
module testbench;

    localparam logic [1:0] MODE_ON       = 2'd1;
    localparam logic [1:0] MODE_ALT      = 2'd3;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SEGMENT_WORDS = 65;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    mbe_pkg::mbe_in_t  in_data   = '0;
    logic              out_ready = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [2:0]        paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic              in_ready;
    logic              out_valid;
    mbe_pkg::mbe_out_t out_data;
    logic [31:0]       prdata;
    logic              pready;
    int                error_count;
    int                pending_words;

    int          send_idle     = 0;
    int          stall_pct     = 0;
    bit          long_hold     = 1'b0;
    logic [1:0]  phys_held     = 2'b00;
    logic [15:0] cur_timeout   = mbe_pkg::TIMEOUT_RESET;
    int          words_sent    = 0;
    int          settings_done = 0;

    middle_button_emulation_fsm dut (.*);

    emulation_checker watch (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one input word after a random idle gap; return at the edge that takes it
    task automatic push_word(input mbe_pkg::mbe_in_t w);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted result word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    // Write both registers with random upper bits, reading each one back
    task automatic apply_settings(input logic [1:0] m, input logic [15:0] t);
        logic [31:0] wr_val;
        logic        idx;
        psel <= 1'b1;
        for (int k = 0; k < 2; k++)
        begin
            idx    = (k == 0) ? mbe_pkg::REG_MODE : mbe_pkg::REG_TIMEOUT;
            wr_val = $urandom();
            if (idx == mbe_pkg::REG_MODE)
                wr_val[1:0] = m;
            else
                wr_val[15:0] = t;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= wr_val;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            // read back
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_timeout = t;
        settings_done++;
    endtask

    function automatic mbe_pkg::mbe_in_t button_word(input logic [4:0] n, input logic p);
        mbe_pkg::mbe_in_t w;
        w.opcode        = mbe_pkg::OP_BUTTON;
        w.button_number = n;
        w.is_press      = p;
        return w;
    endfunction

    // Tick word; the button fields are don't-care, so randomize them
    function automatic mbe_pkg::mbe_in_t tick_word();
        mbe_pkg::mbe_in_t w;
        w.opcode        = mbe_pkg::OP_TICK;
        w.button_number = 5'($urandom_range(31));
        w.is_press      = 1'($urandom_range(1));
        return w;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("middle_button_emulation_fsm verification failed");
        $finish;
    end

    initial
    begin
        int               idle_mix[4];
        int               stall_mix[4];
        int               pick;
        int               burst_max;
        int               seg_end;
        logic             side;
        logic [1:0]       new_mode;
        logic [15:0]      new_timeout;
        mbe_pkg::mbe_in_t w;

        idle_mix  = '{0, 52, 0, 34};
        stall_mix = '{0, 0, 52, 34};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: auto mode, 50 ms; other buttons, field extremes, real middle
        push_word(tick_word());
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b1));
        push_word(button_word(mbe_pkg::BTN_RIGHT, 1'b1));
        push_word(button_word(mbe_pkg::BTN_RIGHT, 1'b0));
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b0));
        push_word(button_word('0, 1'b1));
        push_word(button_word('1, 1'b0));
        push_word(button_word(mbe_pkg::BTN_MIDDLE, 1'b1));
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b1));
        drain();

        // zero timeout fires on the first tick; middle passes when not in auto
        apply_settings(MODE_ON, 16'd0);
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b1));
        push_word(tick_word());
        push_word(tick_word());
        push_word(button_word(mbe_pkg::BTN_RIGHT, 1'b1));
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b0));
        push_word(button_word(mbe_pkg::BTN_MIDDLE, 1'b1));
        push_word(button_word(mbe_pkg::BTN_RIGHT, 1'b0));
        drain();

        // mode three with the longest timeout
        apply_settings(MODE_ALT, 16'hFFFF);
        push_word(button_word(mbe_pkg::BTN_RIGHT, 1'b1));
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b1));
        push_word(tick_word());
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b0));
        push_word(button_word(mbe_pkg::BTN_RIGHT, 1'b0));
        drain();

        // emulation off
        apply_settings(mbe_pkg::MODE_OFF, mbe_pkg::TIMEOUT_RESET);
        push_word(button_word(mbe_pkg::BTN_LEFT, 1'b1));
        push_word(tick_word());
        drain();

        // random gestures over four idle/stall mixes, new settings per segment
        for (int p = 0; p < 4; p++)
        begin
            send_idle = idle_mix[p];
            stall_pct = stall_mix[p];
            for (int s = 0; s < 4; s++)
            begin
                pick     = $urandom_range(9);
                new_mode = (pick == 0) ? mbe_pkg::MODE_OFF : (pick < 4) ? MODE_ON :
                           (pick < 7) ? mbe_pkg::MODE_AUTO : MODE_ALT;
                pick     = $urandom_range(9);
                new_timeout = (pick < 5)  ? 16'($urandom_range(4))  :
                              (pick < 7)  ? 16'($urandom_range(20)) :
                              (pick == 7) ? 16'hFFFF :
                              (pick == 8) ? 16'($urandom()) : mbe_pkg::TIMEOUT_RESET;
                apply_settings(new_mode, new_timeout);

                // hold the receiver off while the sender keeps offering words
                if (p == 0 && s == 1)
                    long_hold = 1'b1;

                seg_end = words_sent + SEGMENT_WORDS;
                while (words_sent < seg_end)
                begin
                    pick = $urandom_range(99);
                    if (pick < 40)
                    begin
                        // tick burst, which may be long enough to expire short timeouts
                        burst_max = (cur_timeout < 16'd7) ? int'(cur_timeout) + 2 : 8;
                        repeat ($urandom_range(burst_max, 1))
                            push_word(tick_word());
                    end
                    else if (pick < 80)
                    begin
                        // toggle a physical left or right button
                        side = 1'($urandom_range(1));
                        push_word(button_word(side ? mbe_pkg::BTN_RIGHT : mbe_pkg::BTN_LEFT,
                                              !phys_held[side]));
                        phys_held[side] = !phys_held[side];
                    end
                    else if (pick < 92)
                        push_word(button_word(5'($urandom_range(31)), 1'($urandom_range(1))));
                    else
                    begin
                        w.opcode        = 1'($urandom_range(1));
                        w.button_number = 5'($urandom_range(31));
                        w.is_press      = 1'($urandom_range(1));
                        push_word(w);
                    end
                end
                drain();
            end
        end

        repeat (4) @(posedge clk);
        $display("Ran %0d input words under %0d register settings and four idle/stall mixes,",
                 words_sent, settings_done);
        $display("with a %0d-cycle output hold-off and timeouts from 0 to 65535 ms.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("middle_button_emulation_fsm verification clean");
        else
            $display("middle_button_emulation_fsm verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mbe_pkg.sv
hdl/mbe_step.sv
hdl/middle_button_emulation_fsm.sv
hdl/mbe_checker.sv
tb/emulation_checker.sv
tb/testbench.sv
